// ===== hw/rtl/imq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue package
// Index width, position map depth, and the operation and status codes.
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned MapDepth = 1024;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_DELETE_MIN = 3'd1,
    OP_PEEK_MIN   = 3'd2,
    OP_CONTAINS   = 3'd3,
    OP_UPDATE     = 3'd4,
    OP_DECREASE   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_CONTAINED = 3'd4
  } status_e;

endpackage

// ===== hw/rtl/indexed_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue
// Binary min-heap of key, payload and element index with a position map.
// ----------------------------------------------------------------------------
// One request is taken at a time and the block stalls its input until the
// result has been transferred. After a request is taken, errors, contains and
// unused codes go through map read and decode to the result, and peek-min
// also reads the root. Moving an entry walks the heap one level per step
// through the single shared comparator: a sift-up step is a parent read, then
// compare and move, and a sift-down step is a left read, a right read, a child
// choice, then compare and move, plus a final write of the moving entry. The
// depth of the heap sets the count of steps. After reset the position map is
// cleared in a pass over its 1024 entries during which no request is taken.
// The result is held in an output register until it is transferred.
module indexed_min_priority_queue
  import imq_pkg::*;
#(
  parameter int unsigned CAPACITY      = 1023,
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IdxW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               op_i,
  input  logic [IdxW-1:0]          index_in_i,
  input  logic [KEY_WIDTH-1:0]     key_in_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [IdxW-1:0]          index_out_o,
  output logic [KEY_WIDTH-1:0]     key_out_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_out_o,
  output logic                     found_o,
  output logic                     is_empty_o,
  output logic [IdxW-1:0]          entry_count_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY + 1);
  localparam int unsigned Depth = 1 << SlotW;

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_MAPRD  = 18'h00004,
    S_DECODE = 18'h00008,
    S_ROOTRD = 18'h00010,
    S_ROOTWT = 18'h00020,
    S_LASTRD = 18'h00040,
    S_LASTWT = 18'h00080,
    S_KEYRD  = 18'h00100,
    S_KEYCHK = 18'h00200,
    S_UPRD   = 18'h00400,
    S_UPCMP  = 18'h00800,
    S_DNRD   = 18'h01000,
    S_DNRDB  = 18'h02000,
    S_DNSEL  = 18'h04000,
    S_DNCMP  = 18'h08000,
    S_FIN    = 18'h10000,
    S_DONE   = 18'h20000
  } state_e;

  // Heap storage memories and position map.
  logic [KEY_WIDTH-1:0]     keys_mem [Depth];
  logic [PAYLOAD_WIDTH-1:0] pays_mem [Depth];
  logic [IdxW-1:0]          idxs_mem [Depth];
  logic [SlotW-1:0]         map_mem  [MapDepth];

  state_e state_q, state_d;
  logic [IdxW-1:0] limit_q;
  logic [IdxW-1:0] clr_q;
  logic [SlotW-1:0] count_q;

  // Request registers.
  logic [2:0] op_q;
  logic [IdxW-1:0] idx_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  // Sift working registers: moving entry for hole slot s, chosen child at c.
  logic [SlotW-1:0] s_q, c_q;
  logic [KEY_WIDTH-1:0] mk_q, ck_q;
  logic [PAYLOAD_WIDTH-1:0] mp_q, cp_q;
  logic [IdxW-1:0] mi_q, ci_q;
  logic down_after_q;

  // Result register.
  logic out_valid_q;
  logic [2:0] status_q;
  logic [IdxW-1:0] iout_q;
  logic [KEY_WIDTH-1:0] kout_q;
  logic [PAYLOAD_WIDTH-1:0] pout_q;
  logic found_q;

  // Registered memory read ports.
  logic [SlotW-1:0] rd_addr;
  logic [KEY_WIDTH-1:0] rd_key_q;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [SlotW-1:0] map_rd_q;

  // Memory write controls.
  logic wr_en, map_we;
  logic [SlotW-1:0] wr_addr, map_wd;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;
  logic [IdxW-1:0] wr_idx, map_wa;

  // Shared comparator.
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic cmp_lt, cmp_le;

  imq_cmp #(.KeyW(KEY_WIDTH)) u_cmp (
    .a_i (cmp_a),
    .b_i (cmp_b),
    .lt_o(cmp_lt),
    .le_o(cmp_le)
  );

  logic in_fire, in_range, map_hit, is_full, ins_ok;
  logic [SlotW-1:0] count_inc;
  assign in_fire   = in_valid_i && !in_stall_o;
  assign in_range  = (idx_q != '0) && (idx_q <= limit_q);
  assign map_hit   = (map_rd_q != '0);
  assign is_full   = (count_q >= SlotW'(CAPACITY));
  assign ins_ok    = in_range && !map_hit && !is_full;
  assign count_inc = count_q + SlotW'(1);

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;

  // Parent and child slots of the hole.
  logic [SlotW-1:0] parent, child_l, child_r;
  logic [SlotW:0] child_l_w, count_w;
  logic has_left, has_right;
  assign parent    = s_q >> 1;
  assign child_l_w = {s_q, 1'b0};
  assign child_l   = child_l_w[SlotW-1:0];
  assign child_r   = child_l | SlotW'(1);
  assign count_w   = {1'b0, count_q};
  assign has_left  = (child_l_w <= count_w);
  assign has_right = (child_l_w < count_w);

  // Compare selection: the decrease test is new < old, the sift-up stop test
  // is parent <= moving, the child choice is right < left and the sift-down
  // move test is child < moving.
  always_comb begin
    case (state_q)
      S_KEYCHK: begin
        cmp_a = key_q;
        cmp_b = rd_key_q;
      end
      S_UPCMP: begin
        cmp_a = rd_key_q;
        cmp_b = mk_q;
      end
      S_DNSEL: begin
        cmp_a = rd_key_q;
        cmp_b = ck_q;
      end
      default: begin
        cmp_a = ck_q;
        cmp_b = mk_q;
      end
    endcase
  end

  // Read address per state.
  always_comb begin
    case (state_q)
      S_ROOTRD: rd_addr = SlotW'(1);
      S_LASTRD: rd_addr = count_inc;
      S_UPRD:   rd_addr = parent;
      S_DNRD:   rd_addr = child_l;
      S_DNRDB:  rd_addr = child_r;
      default:  rd_addr = s_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= keys_mem[rd_addr];
    rd_pay_q <= pays_mem[rd_addr];
    rd_idx_q <= idxs_mem[rd_addr];
    map_rd_q <= map_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_mem[wr_addr] <= wr_key;
      pays_mem[wr_addr] <= wr_pay;
      idxs_mem[wr_addr] <= wr_idx;
    end
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
  end

  // Sequencer next state and memory writes.
  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = s_q;
    wr_key  = mk_q;
    wr_pay  = mp_q;
    wr_idx  = mi_q;
    map_we  = 1'b0;
    map_wa  = mi_q;
    map_wd  = s_q;
    case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q;
        map_wd = '0;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE:  if (in_fire) state_d = S_MAPRD;
      S_MAPRD: state_d = S_DECODE;
      S_DECODE: begin
        state_d = S_DONE;
        case (op_q)
          OP_INSERT:                  if (ins_ok) state_d = S_UPRD;
          OP_DELETE_MIN, OP_PEEK_MIN: if (count_q != '0) state_d = S_ROOTRD;
          OP_UPDATE:                  if (in_range && map_hit) state_d = S_UPRD;
          OP_DECREASE:                if (in_range && map_hit) state_d = S_KEYRD;
          default:                    state_d = S_DONE;
        endcase
      end
      S_ROOTRD: state_d = S_ROOTWT;
      S_ROOTWT: begin
        state_d = S_DONE;
        if (op_q == OP_DELETE_MIN) begin
          // The removed element becomes absent.
          map_we = 1'b1;
          map_wa = rd_idx_q;
          map_wd = '0;
          if (count_q > SlotW'(1)) state_d = S_LASTRD;
        end
      end
      S_LASTRD: state_d = S_LASTWT;
      S_LASTWT: state_d = S_DNRD;
      S_KEYRD:  state_d = S_KEYCHK;
      S_KEYCHK: state_d = cmp_lt ? S_UPRD : S_DONE;
      S_UPRD: begin
        if (s_q == SlotW'(1)) state_d = down_after_q ? S_DNRD : S_FIN;
        else state_d = S_UPCMP;
      end
      S_UPCMP: begin
        if (cmp_le) begin
          state_d = down_after_q ? S_DNRD : S_FIN;
        end else begin
          // Parent moves down into the hole.
          wr_en   = 1'b1;
          wr_key  = rd_key_q;
          wr_pay  = rd_pay_q;
          wr_idx  = rd_idx_q;
          map_we  = 1'b1;
          map_wa  = rd_idx_q;
          state_d = S_UPRD;
        end
      end
      S_DNRD:  state_d = has_left ? S_DNRDB : S_FIN;
      S_DNRDB: state_d = S_DNSEL;
      S_DNSEL: state_d = S_DNCMP;
      S_DNCMP: begin
        if (cmp_lt) begin
          // Chosen child moves up into the hole.
          wr_en   = 1'b1;
          wr_key  = ck_q;
          wr_pay  = cp_q;
          wr_idx  = ci_q;
          map_we  = 1'b1;
          map_wa  = ci_q;
          state_d = S_DNRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        wr_en   = 1'b1;
        map_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= IdxW'(1023);
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_DECODE && op_q == OP_INSERT && ins_ok) begin
        count_q <= count_inc;
      end
      if (state_q == S_ROOTWT && op_q == OP_DELETE_MIN) begin
        count_q <= count_q - SlotW'(1);
      end
    end
  end

  // Request capture, result fields and sift datapath.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      idx_q <= index_in_i;
      key_q <= key_in_i;
      pay_q <= payload_in_i;
    end
    case (state_q)
      S_DECODE: begin
        status_q     <= ST_OK;
        iout_q       <= '0;
        kout_q       <= '0;
        pout_q       <= '0;
        found_q      <= 1'b0;
        mk_q         <= key_q;
        mp_q         <= pay_q;
        mi_q         <= idx_q;
        down_after_q <= (op_q == OP_UPDATE);
        s_q          <= map_rd_q;
        case (op_q)
          OP_INSERT: begin
            if (!in_range) status_q <= ST_RANGE;
            else if (map_hit || is_full) status_q <= ST_CONTAINED;
            s_q <= count_inc;
          end
          OP_DELETE_MIN, OP_PEEK_MIN: begin
            if (count_q == '0) status_q <= ST_EMPTY;
            s_q <= SlotW'(1);
          end
          OP_CONTAINS: begin
            if (!in_range) status_q <= ST_RANGE;
            else found_q <= map_hit;
          end
          OP_UPDATE, OP_DECREASE: begin
            if (!in_range) status_q <= ST_RANGE;
            else if (!map_hit) status_q <= ST_ABSENT;
          end
          default: ;
        endcase
      end
      S_ROOTWT: begin
        iout_q <= rd_idx_q;
        kout_q <= rd_key_q;
        pout_q <= rd_pay_q;
      end
      S_LASTWT: begin
        // The last entry becomes the moving entry with the hole at the root.
        mk_q <= rd_key_q;
        mp_q <= rd_pay_q;
        mi_q <= rd_idx_q;
        s_q  <= SlotW'(1);
      end
      S_UPCMP: if (!cmp_le) s_q <= parent;
      S_DNRDB: begin
        ck_q <= rd_key_q;
        cp_q <= rd_pay_q;
        ci_q <= rd_idx_q;
        c_q  <= child_l;
      end
      S_DNSEL: begin
        if (has_right && cmp_lt) begin
          ck_q <= rd_key_q;
          cp_q <= rd_pay_q;
          ci_q <= rd_idx_q;
          c_q  <= child_r;
        end
      end
      S_DNCMP: if (cmp_lt) s_q <= c_q;
      default: ;
    endcase
  end

  // Output port drive.
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign index_out_o   = iout_q;
  assign key_out_o     = kout_q;
  assign payload_out_o = pout_q;
  assign found_o       = found_q;
  assign is_empty_o    = (count_q == '0);
  assign entry_count_o = IdxW'(count_q);

endmodule

// ===== hw/rtl/imq_cmp.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue key comparator
// The shared compare unit used by every sift step.
// ----------------------------------------------------------------------------
module imq_cmp #(
  parameter int unsigned KeyW = 32
) (
  input  logic [KeyW-1:0] a_i,
  input  logic [KeyW-1:0] b_i,
  output logic            lt_o,
  output logic            le_o
);

  // Unsigned less-than from one subtract; less-or-equal adds an equality test.
  logic [KeyW:0] diff;
  assign diff = {1'b0, a_i} - {1'b0, b_i};
  assign lt_o = diff[KeyW];
  assign le_o = diff[KeyW] | (a_i == b_i);

endmodule

// ===== hw/rtl/imq_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue port checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module imq_checker
  import imq_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [2:0]      status_o,
  input logic            is_empty_o,
  input logic [IdxW-1:0] entry_count_o
);

  // A stalled request stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("request withdrawn while stalled");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // No request is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken with result pending");

  // Empty flag agrees with the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_empty_o == (entry_count_o == '0))
    else $error("empty flag mismatch");

  // Status is one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_CONTAINED)
    else $error("bad status code");

endmodule

bind indexed_min_priority_queue imq_checker u_imq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .is_empty_o   (is_empty_o),
  .entry_count_o(entry_count_o)
);
